// File: rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the wavetable sample player.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  // Default geometry of the player.
  localparam int unsigned TableDepthDef   = 4096;
  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned GainFracBitsDef = 12;

  // Fixed register widths.
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Gain after reset: unity in Q4.12.
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_PLAY    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ONESHOT  = 2'd0,
    MODE_LOOP     = 2'd1,
    MODE_PINGPONG = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAY_MODE    = 2'd0,
    CFG_TABLE_LENGTH = 2'd1,
    CFG_GAIN         = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

// File: rtl/wsp_if.sv
// ----------------------------------------------------------------------------
// wsp_in_if / wsp_out_if
// Valid/ready channels of the wavetable sample player.
// ----------------------------------------------------------------------------
`default_nettype none

interface wsp_in_if #(
  parameter int unsigned IDX_W    = 12,
  parameter int unsigned SAMPLE_W = 16
);
  logic                       valid;
  logic                       ready;
  wsp_pkg::op_e               op;
  logic [IDX_W-1:0]           entry_index;
  logic signed [SAMPLE_W-1:0] entry_value;

  modport source (output valid, op, entry_index, entry_value, input ready);
  modport sink   (input valid, op, entry_index, entry_value, output ready);
endinterface

interface wsp_out_if #(
  parameter int unsigned SAMPLE_W = 16,
  parameter int unsigned POS_W    = 13
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [POS_W-1:0]           position_played;
  logic                       at_end;

  modport source (output valid, sample_out, position_played, at_end, input ready);
  modport sink   (input valid, sample_out, position_played, at_end, output ready);
endinterface

`default_nettype wire

// File: rtl/wsp_scale.sv
// ----------------------------------------------------------------------------
// wsp_scale
// Gain multiply, round-half-up and saturation, two registered stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_scale #(
  parameter int unsigned SAMPLE_W       = 16,
  parameter int unsigned GAIN_FRAC_BITS = 12,
  parameter int unsigned POS_W          = 13
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic signed [SAMPLE_W-1:0]      sample_i,
  input  wire logic [POS_W-1:0]                pos_i,
  input  wire logic                            at_end_i,
  input  wire logic [wsp_pkg::GAIN_W-1:0]      gain_i,
  wsp_out_if.source                            out_if
);
  import wsp_pkg::*;

  localparam int unsigned PW = SAMPLE_W + GAIN_W + 1;
  localparam logic signed [PW-1:0] HALF =
    {{(PW-1){1'b0}}, 1'b1} << (GAIN_FRAC_BITS - 1);

  logic                     p_valid_q;
  logic signed [PW-1:0]     prod_q;
  logic [POS_W-1:0]         p_pos_q;
  logic                     p_end_q;
  logic                     o_valid_q;
  logic signed [SAMPLE_W-1:0] o_sample_q;
  logic [POS_W-1:0]         o_pos_q;
  logic                     o_end_q;

  logic                     p_en;
  logic                     o_en;
  logic signed [GAIN_W:0]   gain_ext;
  logic signed [PW-1:0]     prod_d;
  logic signed [PW-1:0]     rounded;
  logic signed [PW-1:0]     shifted;
  logic                     fits;
  logic signed [SAMPLE_W-1:0] sat_d;

  assign o_en    = !o_valid_q || out_if.ready;
  assign p_en    = !p_valid_q || o_en;
  assign ready_o = p_en;

  assign gain_ext = $signed({1'b0, gain_i});
  assign prod_d   = sample_i * gain_ext;

  // Round half up, then clip to the sample range.
  assign rounded = prod_q + HALF;
  assign shifted = rounded >>> GAIN_FRAC_BITS;
  assign fits    = (&shifted[PW-1:SAMPLE_W-1]) || !(|shifted[PW-1:SAMPLE_W-1]);

  always_comb begin
    if (fits) begin
      sat_d = shifted[SAMPLE_W-1:0];
    end else if (shifted[PW-1]) begin
      sat_d = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_en) begin
        p_valid_q <= valid_i;
      end
      if (o_en) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en && valid_i) begin
      prod_q  <= prod_d;
      p_pos_q <= pos_i;
      p_end_q <= at_end_i;
    end
    if (o_en && p_valid_q) begin
      o_sample_q <= sat_d;
      o_pos_q    <= p_pos_q;
      o_end_q    <= p_end_q;
    end
  end

  assign out_if.valid           = o_valid_q;
  assign out_if.sample_out      = o_sample_q;
  assign out_if.position_played = o_pos_q;
  assign out_if.at_end          = o_end_q;

endmodule

`default_nettype wire

// File: rtl/wavetable_sample_player_core.sv
// ----------------------------------------------------------------------------
// wavetable_sample_player_core
// Sample table with one-shot, loop and ping-pong playback and gain scaling.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake        Payload
//  in_if     in   valid/ready      op, entry_index, entry_value
//  out_if    out  valid/ready      sample_out, position_played, at_end
//  cfg       in   cfg_we_i only    cfg_index_i, cfg_data_i
//
//  One transaction is taken every cycle while the output side drains.
//  A play tick passes three register stages (table read, gain multiply,
//  round and saturate) and is offered on out_if from the last one.
//  Write and restart transactions take effect at their accept edge and
//  give no result; a play accepted next cycle already sees them.
//  Reset restores config, position, direction and stages, not the table.
//  A stall on out_if backs up through the stages and drops in_if.ready.
//
`default_nettype none

module wavetable_sample_player_core #(
  parameter int unsigned TABLE_DEPTH    = wsp_pkg::TableDepthDef,
  parameter int unsigned SAMPLE_BITS    = wsp_pkg::SampleBitsDef,
  parameter int unsigned GAIN_FRAC_BITS = wsp_pkg::GainFracBitsDef,
  localparam int unsigned POS_W = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned CFG_W = (POS_W > wsp_pkg::GAIN_W) ? POS_W : wsp_pkg::GAIN_W
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wsp_in_if.sink                               in_if,
  wsp_out_if.source                            out_if,
  input  wire logic                            cfg_we_i,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]                cfg_data_i
);
  import wsp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(TABLE_DEPTH);

  // Configuration registers.
  logic [MODE_W-1:0] mode_q;
  logic [POS_W-1:0]  len_q;
  logic [GAIN_W-1:0] gain_q;

  // Playback state.
  logic [POS_W-1:0] pos_q, pos_d;
  logic             dir_q, dir_d;

  // Table read stage.
  logic                          r_valid_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic [POS_W-1:0]              r_pos_q;
  logic                          r_silent_q;
  logic                          r_end_q;

  logic signed [SAMPLE_BITS-1:0] table_mem [TABLE_DEPTH];

  logic             r_en;
  logic             scale_ready;
  logic             in_acc;
  logic             play_acc;
  logic             wr_acc;
  logic [POS_W-1:0] len_act;
  logic [POS_W:0]   pos_inc;
  logic             silent;
  logic             at_end;
  logic signed [SAMPLE_BITS-1:0] sample_sel;

  // Hold the read stage while the scaler is full.
  assign r_en        = !r_valid_q || scale_ready;
  assign in_if.ready = r_en;
  assign in_acc      = in_if.valid && r_en;
  assign play_acc    = in_acc && (in_if.op == OP_PLAY);
  assign wr_acc      = in_acc && (in_if.op == OP_WRITE)
                    && (POS_W'(in_if.entry_index) < DEPTH_P);

  // A length past the table depth plays as the full table.
  assign len_act = (len_q > DEPTH_P) ? DEPTH_P : len_q;
  assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign silent  = (pos_q >= len_act);
  assign at_end  = (mode_q == MODE_ONESHOT) && silent;

  // Advance the position after each tick per play mode; a restart rewinds it.
  always_comb begin
    pos_d = pos_q;
    dir_d = dir_q;
    unique case (in_if.op)
      OP_RESTART: begin
        pos_d = '0;
        dir_d = 1'b1;
      end
      OP_PLAY: begin
        unique case (mode_q)
          MODE_ONESHOT: begin
            if (pos_q < len_act) begin
              pos_d = pos_inc[POS_W-1:0];
            end
          end
          MODE_PINGPONG: begin
            if (len_act < POS_W'(2)) begin
              pos_d = '0;
              dir_d = 1'b1;
            end else if (dir_q) begin
              // Turn at the top and step back to the second-last entry.
              if (pos_inc >= {1'b0, len_act}) begin
                pos_d = len_act - POS_W'(2);
                dir_d = 1'b0;
              end else begin
                pos_d = pos_inc[POS_W-1:0];
              end
            end else begin
              // Turn below entry 0 and go on at entry 1.
              if (pos_q == '0) begin
                pos_d = POS_W'(1);
                dir_d = 1'b1;
              end else begin
                pos_d = pos_q - POS_W'(1);
              end
            end
          end
          default: begin
            // Loop, and the unused mode code.
            if (pos_inc >= {1'b0, len_act}) begin
              pos_d = '0;
            end else begin
              pos_d = pos_inc[POS_W-1:0];
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_LOOP;
      len_q     <= DEPTH_P;
      gain_q    <= GAIN_RESET;
      pos_q     <= '0;
      dir_q     <= 1'b1;
      r_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_PLAY_MODE:    mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_TABLE_LENGTH: len_q  <= cfg_data_i[POS_W-1:0];
          CFG_GAIN:         gain_q <= cfg_data_i[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        pos_q <= pos_d;
        dir_q <= dir_d;
      end
      if (r_en) begin
        r_valid_q <= play_acc;
      end
    end
  end

  // Sample table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_acc) begin
      table_mem[in_if.entry_index] <= in_if.entry_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (play_acc) begin
      rd_data_q  <= table_mem[pos_q[IDX_W-1:0]];
      r_pos_q    <= pos_q;
      r_silent_q <= silent;
      r_end_q    <= at_end;
    end
  end

  // Past the length the tick plays silence.
  assign sample_sel = r_silent_q ? '0 : rd_data_q;

  wsp_scale #(
    .SAMPLE_W       (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .POS_W          (POS_W)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (r_valid_q),
    .ready_o  (scale_ready),
    .sample_i (sample_sel),
    .pos_i    (r_pos_q),
    .at_end_i (r_end_q),
    .gain_i   (gain_q),
    .out_if   (out_if)
  );

  // The position never runs past the table depth.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= DEPTH_P)
    else $error("play position beyond table depth");

  // An accepted tick always lands in the read stage.
  a_play_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_acc |=> r_valid_q)
    else $error("accepted play tick lost before read stage");

  // Ping-pong on a short table parks at entry 0 going forward.
  a_short_pingpong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    play_acc && (mode_q == MODE_PINGPONG) && (len_act < POS_W'(2))
    |=> (pos_q == '0) && dir_q)
    else $error("short ping-pong table did not park at entry 0");

  // The silent end frame carries no signal.
  a_end_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.at_end |-> out_if.sample_out == '0)
    else $error("end frame carries a nonzero sample");

endmodule

`default_nettype wire

// File: tb/sv/wsp_tick_checker.sv
// ----------------------------------------------------------------------------
// wsp_tick_checker
// Watches the wavetable player channels and its register port, predicts the
// result of every play transaction and compares it with what the block emits.
// ----------------------------------------------------------------------------

module wsp_tick_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  wsp_in_if                                in_mon,
  wsp_out_if                               out_mon,
  input  logic                             cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                      cfg_data_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output logic [12:0]                      next_pos_o,
  output logic                             next_in_table_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wsp_pkg::*;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned FracBits   = 12;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [12:0]        pos;
    logic               at_end;
  } tick_result_t;

  logic signed [15:0] sample_mem [TableDepth];
  logic [1:0]         mode;
  logic [12:0]        length;
  logic [15:0]        level;
  logic [12:0]        cursor;
  logic               forward;

  tick_result_t       tick_q [$];
  tick_result_t       want;
  logic [12:0]        span;
  logic signed [15:0] fetched;
  int unsigned        fails;

  function automatic logic [12:0] span_in_use();
    return (length > 13'(TableDepth)) ? 13'(TableDepth) : length;
  endfunction

  // Q4.12 scaling, ties rounded up, then clamp to 16 bits.
  function automatic logic signed [15:0] scale_sample(logic signed [15:0] s,
                                                       logic [15:0] g);
    longint prod;
    longint q;
    prod = longint'(s) * longint'({48'd0, g});
    q    = (prod + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic void move_cursor(logic [12:0] n);
    case (mode)
      MODE_ONESHOT: begin
        if (cursor < n) cursor = cursor + 13'd1;
      end
      MODE_PINGPONG: begin
        if (n < 13'd2) begin
          cursor  = '0;
          forward = 1'b1;
        end else if (forward) begin
          cursor = cursor + 13'd1;
          if (cursor >= n) begin
            cursor  = n - 13'd2;
            forward = 1'b0;
          end
        end else if (cursor == '0) begin
          cursor  = 13'd1;
          forward = 1'b1;
        end else begin
          cursor = cursor - 13'd1;
        end
      end
      default: begin
        cursor = cursor + 13'd1;
        if (cursor >= n) cursor = '0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode    = MODE_LOOP;
      length  = 13'(TableDepth);
      level   = GAIN_RESET;
      cursor  = '0;
      forward = 1'b1;
    end else begin
      // Match emitted results first so an output never pairs with a tick
      // taken on the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (tick_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: sample %0d pos %0d",
                                    out_mon.sample_out, out_mon.position_played));
        end else begin
          want = tick_q.pop_front();
          if (out_mon.sample_out !== want.sample)
            report_mismatch($sformatf("sample_out %0d, want %0d at pos %0d",
                                      out_mon.sample_out, want.sample, want.pos));
          if (out_mon.position_played !== want.pos)
            report_mismatch($sformatf("position_played %0d, want %0d",
                                      out_mon.position_played, want.pos));
          if (out_mon.at_end !== want.at_end)
            report_mismatch($sformatf("at_end %b, want %b at pos %0d",
                                      out_mon.at_end, want.at_end, want.pos));
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PLAY_MODE:    mode   = cfg_data_i[1:0];
          CFG_TABLE_LENGTH: length = cfg_data_i[12:0];
          CFG_GAIN:         level  = cfg_data_i;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_WRITE: sample_mem[in_mon.entry_index] = in_mon.entry_value;
          OP_RESTART: begin
            cursor  = '0;
            forward = 1'b1;
          end
          OP_PLAY: begin
            span    = span_in_use();
            // Past the length in use the tick plays silence.
            fetched = (cursor < span) ? sample_mem[cursor[11:0]] : '0;
            want.sample = scale_sample(fetched, level);
            want.pos    = cursor;
            want.at_end = (mode == MODE_ONESHOT) && (cursor >= span);
            tick_q.push_back(want);
            move_cursor(span);
          end
          default: ;
        endcase
      end
    end
    fail_count_o    = fails;
    pending_o       = tick_q.size();
    next_pos_o      = cursor;
    next_in_table_o = cursor < span_in_use();
  end

endmodule

// File: tb/sv/tb_wavetable_sample_player_core.sv
// ----------------------------------------------------------------------------
// tb_wavetable_sample_player_core
// Drives write, play, restart and unused transactions into the player across
// many mode, length and gain settings, with random gaps and output stalls;
// a checker beside the block predicts and compares every played sample.
// ----------------------------------------------------------------------------

module tb_wavetable_sample_player_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wsp_pkg::*;

  localparam int unsigned TableDepth  = 4096;
  localparam int unsigned HoldCycles  = 400;   // long output hold-off
  localparam int unsigned DrainCycles = 8;     // pipeline depth plus margin
  localparam int unsigned PhaseItems  = 90;
  localparam int unsigned PhaseCount  = 14;
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam logic [1:0]  ModeUnused  = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_index;
  logic [15:0] cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  logic [12:0] next_pos;
  logic        next_in_table;

  // Entries written so far; a play never reads one outside this set.
  bit entry_loaded [TableDepth];
  bit idling_on;
  bit hold_request;

  wsp_in_if  in_ch ();
  wsp_out_if out_ch ();

  wavetable_sample_player_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wsp_tick_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .next_pos_o      (next_pos),
    .next_in_table_o (next_in_table)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, ready stretches, and one long hold-off on
  // request so the pipeline fills and the input side backs up.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3: return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd2;
      3: return 13'd4096;
      4: return 13'd8191;
      5, 6: return 13'($urandom_range(3, 16));
      default: return 13'($urandom_range(17, 300));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return GAIN_RESET;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one transaction, hold it until accepted, return on a falling edge.
  task automatic drive_item(op_e op, logic [11:0] idx, logic signed [15:0] val);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.op          = op;
    in_ch.entry_index = idx;
    in_ch.entry_value = val;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    if (op == OP_WRITE) entry_loaded[idx] = 1'b1;
  endtask

  // Load the entry a tick is about to read if it was never written.
  task automatic play_tick();
    if (next_in_table && !entry_loaded[next_pos[11:0]])
      drive_item(OP_WRITE, next_pos[11:0], rand_sample());
    drive_item(OP_PLAY, 12'($urandom), 16'($urandom));
  endtask

  // Drop valid and wait until every tick has come out and the pipe is empty.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_setting(logic [1:0] mode, logic [12:0] len, logic [15:0] level);
    settle();
    write_cfg(CFG_PLAY_MODE, {14'd0, mode});
    write_cfg(CFG_TABLE_LENGTH, {3'd0, len});
    write_cfg(CFG_GAIN, level);
  endtask

  // Mostly plays, with writes anywhere in the table, restarts, and unused
  // ops mixed in; the unused ones do not count toward the total.
  task automatic run_random(int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        play_tick();
      end else if (pick < 82) begin
        drive_item(OP_WRITE, 12'($urandom_range(0, TableDepth - 1)), rand_sample());
      end else if (pick < 92) begin
        drive_item(OP_RESTART, 12'($urandom), 16'($urandom));
      end else begin
        drive_item(op_e'(OpUnused), 12'($urandom), 16'($urandom));
      end
      if (pick < 92) done++;
    end
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_PLAY_MODE;
    cfg_data          = '0;
    idling_on         = 1'b1;
    hold_request      = 1'b0;
    rst_ni            = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting (loop, full table, unity): extreme samples, the top
    // index, an unused op, then ticks over the loaded entries.
    drive_item(OP_WRITE, 12'd0, 16'sh7FFF);
    drive_item(OP_WRITE, 12'd1, 16'sh8000);
    drive_item(OP_WRITE, 12'd2, 16'sd1);
    drive_item(OP_WRITE, 12'd3, -16'sd1);
    drive_item(OP_WRITE, 12'd4095, -16'sd2);
    drive_item(op_e'(OpUnused), 12'hFFF, 16'shFFFF);
    play_tick();
    play_tick();
    play_tick();
    drive_item(OP_RESTART, 12'd0, 16'sd0);
    play_tick();

    // One-shot on three entries at full gain: saturate both ways, then sit
    // on the silent end frame.
    apply_setting(MODE_ONESHOT, 13'd3, 16'hFFFF);
    drive_item(OP_RESTART, 12'd0, 16'sd0);
    repeat (5) play_tick();

    // Half gain hits the rounding ties; ping-pong from the end frame turns
    // at the top and at the bottom.
    apply_setting(MODE_PINGPONG, 13'd4, 16'd2048);
    repeat (6) play_tick();

    // Ping-pong on a one-entry table holds at zero.
    apply_setting(MODE_PINGPONG, 13'd1, GAIN_RESET);
    play_tick();

    // Unused mode acts as loop; zero length gives only silence.
    apply_setting(ModeUnused, 13'd0, GAIN_RESET);
    play_tick();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: apply_setting(MODE_LOOP, 13'd4096, 16'd0);
        1: apply_setting(MODE_PINGPONG, 13'd8191, 16'hFFFF);
        2: apply_setting(MODE_PINGPONG, 13'd12, GAIN_RESET);
        default: apply_setting(2'($urandom_range(0, 3)), pick_length(), pick_gain());
      endcase
      // Keep the last phase free of gaps and stalls; otherwise idle in
      // most phases.
      idling_on = (ph != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
      if (ph == 2) hold_request = 1'b1;
      run_random(PhaseItems);
    end

    in_ch.valid = 1'b0;
    for (int n = 0; n < 5000 && pending != 0; n++) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (pending != 0) $display("%0d play results never arrived", pending);

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
